@@ src/bounded_deque_engine_macros.svh @@
// ----------------------------------------------------------------------------
// Bounded deque engine assertion macros
// Concurrent assertion forms used by the deque engine datapath.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ENGINE_MACROS_SVH
`define BOUNDED_DEQUE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define BDE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque engine assertion failed");

// Next-cycle implication, checked outside reset.
`define BDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque engine assertion failed");

`else

`define BDE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define BDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/bde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine package
// Item types, action and status codes, and controller/datapath interface.
// ----------------------------------------------------------------------------
package bde_pkg;

	localparam int DATA_W = 32;

	// Requested action of an input item; codes 5 to 7 are ignored.
	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_PEEK_FRONT = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_DUMP       = 3'd4
	} bde_action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} bde_status_t;

	// Source of a result item.
	typedef enum logic [1:0] {
		SEL_ECHO,
		SEL_OVER,
		SEL_UNDER,
		SEL_MEM
	} bde_sel_t;

	typedef struct packed {
		bde_action_t              action;
		logic signed [DATA_W-1:0] value;
	} bde_cmd_t;

	typedef struct packed {
		bde_status_t              status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} bde_result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     write;
		logic     pop;
		logic     step;
		logic     emit;
		bde_sel_t sel;
		logic     last;
	} bde_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		bde_action_t action;
		logic        empty;
		logic        full;
		logic        walk_last;
	} bde_sts_t;

endpackage

@@ src/bde_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine controller
// Accepts items, sequences pushes, reads and dump walks, strobes results.
// ----------------------------------------------------------------------------
module bde_ctrl import bde_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  bde_sts_t sts,
	output bde_ctl_t ctl,
	output logic     busy,
	output logic     valid
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	state_t state_d;

	// Decode the latched action against the queue status.
	always_comb begin
		ctl     = '0;
		ctl.sel = SEL_UNDER;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (sts.action)
					ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
						ctl.emit = 1'b1;
						ctl.last = 1'b1;
						if (sts.full) begin
							ctl.sel = SEL_OVER;
						end else begin
							ctl.sel   = SEL_ECHO;
							ctl.write = 1'b1;
						end
					end
					ACT_PEEK_FRONT, ACT_POP_BACK: begin
						ctl.emit = 1'b1;
						ctl.last = 1'b1;
						if (sts.empty) begin
							ctl.sel = SEL_UNDER;
						end else begin
							ctl.sel = SEL_MEM;
							ctl.pop = (sts.action == ACT_POP_BACK);
						end
					end
					ACT_DUMP: begin
						ctl.emit = 1'b1;
						if (sts.empty) begin
							ctl.sel  = SEL_UNDER;
							ctl.last = 1'b1;
						end else begin
							// One entry per cycle while the next one is read.
							ctl.sel  = SEL_MEM;
							ctl.last = sts.walk_last;
							ctl.step = 1'b1;
							if (!sts.walk_last) begin
								state_d = S_EXEC;
							end
						end
					end
					default: begin
						ctl.emit = 1'b0;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			valid   <= ctl.emit;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ src/bde_datapath.sv @@
`timescale 1ns / 1ps
`include "bounded_deque_engine_macros.svh"
// ----------------------------------------------------------------------------
// Bounded deque engine datapath
// Ring memory, head and count registers, walk counter and result register.
// ----------------------------------------------------------------------------
module bde_datapath import bde_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bde_cmd_t    cmd,
	input  bde_ctl_t    ctl,
	output bde_sts_t    sts,
	output bde_result_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     walk_q;
	logic [CW-1:0]     walk_nxt;
	bde_cmd_t          cmd_q;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     head_m1;

	// Position offset entries past base, wrapped once around the ring.
	function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] ofs);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(ofs);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign walk_nxt = walk_q + CW'(1);
	assign head_m1  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

	// Read address: first access at accept, next dump entry while walking.
	always_comb begin
		rd_addr = head_q;
		if (ctl.load) begin
			if (cmd.action == ACT_POP_BACK) begin
				rd_addr = ring_pos(head_q, count_q - CW'(1));
			end else begin
				rd_addr = head_q;
			end
		end else if (ctl.step) begin
			rd_addr = ring_pos(head_q, walk_nxt);
		end
	end

	assign wr_addr = (cmd_q.action == ACT_PUSH_FRONT) ? head_m1 : ring_pos(head_q, count_q);

	// Element memory with registered read data.
	always_ff @(posedge clk) begin
		if (ctl.write) begin
			mem[wr_addr] <= cmd_q.value;
		end
		rdata_q <= mem[rd_addr];
	end

	// Queue pointers and walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			walk_q  <= '0;
		end else begin
			if (ctl.write) begin
				count_q <= count_q + CW'(1);
				if (cmd_q.action == ACT_PUSH_FRONT) begin
					head_q <= head_m1;
				end
			end else if (ctl.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.load) begin
				walk_q <= '0;
			end else if (ctl.step) begin
				walk_q <= walk_nxt;
			end
		end
	end

	// Latched item and result register.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
		end
		if (ctl.emit) begin
			result.last <= ctl.last;
			unique case (ctl.sel)
				SEL_ECHO: begin
					result.status <= ST_OK;
					result.data   <= cmd_q.value;
				end
				SEL_OVER: begin
					result.status <= ST_OVER;
					result.data   <= cmd_q.value;
				end
				SEL_UNDER: begin
					result.status <= ST_UNDER;
					result.data   <= '0;
				end
				SEL_MEM: begin
					result.status <= ST_OK;
					result.data   <= rdata_q;
				end
				default: begin
					result.status <= ST_UNDER;
					result.data   <= '0;
				end
			endcase
		end
	end

	assign sts.action    = cmd_q.action;
	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.walk_last = (walk_nxt == count_q);

	`BDE_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`BDE_ASSERT_IMPLY(a_no_write_full, clk, arst_n, ctl.write, !sts.full)
	`BDE_ASSERT_IMPLY(a_no_pop_empty, clk, arst_n, ctl.pop, !sts.empty)
	`BDE_ASSERT_IMPLY(a_step_dump, clk, arst_n, ctl.step, cmd_q.action == ACT_DUMP)
	`BDE_ASSERT_NEXT(a_write_grows, clk, arst_n, ctl.write, count_q == $past(count_q) + CW'(1))

endmodule

@@ src/bounded_deque_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine
// Double-ended queue of signed 32-bit values held in a ring memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals              Transfer
// command   in         start, busy, cmd     taken when start is high and busy low
// result    out        valid, result        valid for one cycle, always taken
//
// Push, peek, pop and ignored codes pass through accept (memory read issued)
// and execute. A dump walks its entries in order, each read while the one before
// is emitted, bound by the single memory read port. A new item is taken while the
// last result shows. Reset clears head, count, walk counter, state and valid;
// the memory needs no clearing pass. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module bounded_deque_engine import bde_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  bde_cmd_t    cmd,
	output logic        busy,
	output logic        valid,
	output bde_result_t result
);

	bde_ctl_t ctl;
	bde_sts_t sts;

	bde_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.valid  (valid)
	);

	bde_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

endmodule
